// ===== rtl/sda_pkg.sv =====
package sda_pkg;

  // Fixed field widths of the operand and result ports.
  localparam int VW = 64;
  localparam int SW = 5;
  localparam int FW = 4;

  // The divider resolves one quotient bit per stage, after one stage that takes magnitudes.
  localparam int DIV_BITS = VW;
  localparam int DIV_LAT = DIV_BITS + 1;

  typedef enum logic [FW-1:0] {
    FN_ADD   = 4'd0,
    FN_SUB   = 4'd1,
    FN_CMP   = 4'd2,
    FN_MUL   = 4'd3,
    FN_DIV   = 4'd4,
    FN_NEG   = 4'd5,
    FN_INC   = 4'd6,
    FN_DEC   = 4'd7,
    FN_SPLIT = 4'd8
  } func_t;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_OVF = 2'd1,
    ST_DZ  = 2'd2
  } status_t;

  // Classified transaction as it waits in the queue between front and back.
  typedef struct packed {
    logic                 known;
    func_t                op;
    logic signed [VW-1:0] a;
    logic signed [VW-1:0] b;
    logic signed [VW-1:0] k;
    logic [SW-1:0]        sa;
    logic [SW-1:0]        smax;
    logic signed [VW-1:0] m1;
    logic signed [VW-1:0] m2;
    logic [VW-1:0]        pw;
  } cmd_t;

  // Context while the multipliers are busy.
  typedef struct packed {
    logic                 valid;
    logic                 known;
    func_t                op;
    logic signed [VW-1:0] a;
    logic                 b_pos;
    logic                 k_zero;
    logic                 k_neg;
    logic [SW-1:0]        sa;
    logic [SW-1:0]        smax;
    logic [VW-1:0]        pw;
  } early_t;

  // Context once the aligned products are known.
  typedef struct packed {
    logic                 valid;
    logic                 known;
    func_t                op;
    logic                 a_neg;
    logic                 b_pos;
    logic                 k_zero;
    logic                 k_neg;
    logic [SW-1:0]        sa;
    logic [SW-1:0]        smax;
    logic signed [VW-1:0] x;
    logic signed [VW-1:0] y;
    logic                 ov1;
    logic                 ov2;
    logic signed [VW-1:0] rv;
    status_t              st;
  } mid_t;

  // Context while the divider finishes.
  typedef struct packed {
    logic                 valid;
    logic                 known;
    func_t                op;
    logic                 a_neg;
    logic                 k_zero;
    logic                 k_neg;
    logic [SW-1:0]        rs;
    logic signed [VW-1:0] rv;
    logic                 eq;
    logic                 lt;
    status_t              st;
  } late_t;

  // Exact powers of ten up to ten to the eighteenth.
  function automatic logic [VW-1:0] pow_ten(input logic [SW-1:0] n);
    logic [VW-1:0] r;
    case (n)
      5'd0:    r = 64'd1;
      5'd1:    r = 64'd10;
      5'd2:    r = 64'd100;
      5'd3:    r = 64'd1000;
      5'd4:    r = 64'd10000;
      5'd5:    r = 64'd100000;
      5'd6:    r = 64'd1000000;
      5'd7:    r = 64'd10000000;
      5'd8:    r = 64'd100000000;
      5'd9:    r = 64'd1000000000;
      5'd10:   r = 64'd10000000000;
      5'd11:   r = 64'd100000000000;
      5'd12:   r = 64'd1000000000000;
      5'd13:   r = 64'd10000000000000;
      5'd14:   r = 64'd100000000000000;
      5'd15:   r = 64'd1000000000000000;
      5'd16:   r = 64'd10000000000000000;
      5'd17:   r = 64'd100000000000000000;
      default: r = 64'd1000000000000000000;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/sda_front.sv =====
module sda_front #(
  parameter int MAX_SCALE   = 18,
  parameter int VALUE_WIDTH = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [sda_pkg::FW-1:0]        func,
  input  logic signed [sda_pkg::VW-1:0] a_value,
  input  logic [sda_pkg::SW-1:0]        a_scale,
  input  logic signed [sda_pkg::VW-1:0] b_value,
  input  logic [sda_pkg::SW-1:0]        b_scale,
  input  logic signed [sda_pkg::VW-1:0] int_operand,
  output sda_pkg::cmd_t                 head,
  output logic                          head_valid,
  input  logic                          pop
);

  localparam int SH = sda_pkg::VW - VALUE_WIDTH;
  localparam logic [sda_pkg::SW-1:0] SCALE_TOP = sda_pkg::SW'(MAX_SCALE);

  sda_pkg::cmd_t cmd;
  sda_pkg::cmd_t q [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;
  logic          push;

  // Classify the incoming transaction: clamp scales, narrow operands, pick multiplier inputs.
  always_comb begin
    cmd.known = (func <= sda_pkg::FN_SPLIT);
    cmd.op    = cmd.known ? sda_pkg::func_t'(func) : sda_pkg::FN_ADD;
    cmd.a     = (a_value <<< SH) >>> SH;
    cmd.b     = (b_value <<< SH) >>> SH;
    cmd.k     = (int_operand <<< SH) >>> SH;
    cmd.sa    = (a_scale > SCALE_TOP) ? SCALE_TOP : a_scale;
    cmd.smax  = (b_scale > SCALE_TOP) ? SCALE_TOP : b_scale;
    cmd.m2    = signed'(sda_pkg::pow_ten('0));
    if (cmd.sa > cmd.smax) begin
      cmd.m2   = signed'(sda_pkg::pow_ten(cmd.sa - cmd.smax));
      cmd.smax = cmd.sa;
    end
    cmd.m1 = (cmd.op == sda_pkg::FN_MUL) ? cmd.k
                                          : signed'(sda_pkg::pow_ten(cmd.smax - cmd.sa));
    cmd.pw = sda_pkg::pow_ten(cmd.sa);
  end

  // Two-entry queue that lets the front keep taking transactions while the back is stalled.
  assign in_stall   = (count == 2'd2);
  assign push       = in_valid && !in_stall;
  assign head_valid = (count != 2'd0);
  assign head       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= cmd;
    end
  end

endmodule

// ===== rtl/sda_mul.sv =====
module sda_mul (
  input  logic                           clk,
  input  logic                           en,
  input  logic signed [sda_pkg::VW-1:0]  x,
  input  logic signed [sda_pkg::VW-1:0]  y,
  output logic signed [2*sda_pkg::VW-1:0] p
);

  localparam int HW = sda_pkg::VW / 2;

  logic [sda_pkg::VW-1:0]   xm;
  logic [sda_pkg::VW-1:0]   ym;
  logic [sda_pkg::VW-1:0]   pp [4];
  logic [2*sda_pkg::VW-1:0] mag;
  logic                     n1;
  logic                     n2;
  logic                     n3;
  logic signed [2*sda_pkg::VW-1:0] p_r;

  // Four stages: magnitudes, half-width partial products, their sum, then the sign.
  always_ff @(posedge clk) begin
    if (en) begin
      xm    <= x[sda_pkg::VW-1] ? sda_pkg::VW'(-x) : sda_pkg::VW'(x);
      ym    <= y[sda_pkg::VW-1] ? sda_pkg::VW'(-y) : sda_pkg::VW'(y);
      n1    <= x[sda_pkg::VW-1] ^ y[sda_pkg::VW-1];
      pp[0] <= sda_pkg::VW'(xm[HW-1:0]) * sda_pkg::VW'(ym[HW-1:0]);
      pp[1] <= sda_pkg::VW'(xm[2*HW-1:HW]) * sda_pkg::VW'(ym[HW-1:0]);
      pp[2] <= sda_pkg::VW'(xm[HW-1:0]) * sda_pkg::VW'(ym[2*HW-1:HW]);
      pp[3] <= sda_pkg::VW'(xm[2*HW-1:HW]) * sda_pkg::VW'(ym[2*HW-1:HW]);
      n2    <= n1;
      mag   <= {{sda_pkg::VW{1'b0}}, pp[0]}
             + {{HW{1'b0}}, pp[1], {HW{1'b0}}}
             + {{HW{1'b0}}, pp[2], {HW{1'b0}}}
             + {pp[3], {sda_pkg::VW{1'b0}}};
      n3    <= n2;
      p_r   <= n3 ? -signed'(mag) : signed'(mag);
    end
  end

  assign p = p_r;

endmodule

// ===== rtl/sda_div.sv =====
module sda_div (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [sda_pkg::VW-1:0] n,
  input  logic signed [sda_pkg::VW-1:0] d,
  output logic [sda_pkg::VW-1:0]        q,
  output logic [sda_pkg::VW-1:0]        r
);

  localparam int NB = sda_pkg::DIV_BITS;

  logic [NB-1:0] rem   [0:NB];
  logic [NB-1:0] num   [0:NB];
  logic [NB-1:0] dvs   [0:NB];
  logic [NB:0]   trial [1:NB];
  logic          take  [1:NB];

  // Each stage shifts in one dividend bit and subtracts the divisor where it fits.
  always_comb begin
    for (int i = 1; i <= NB; i++) begin
      trial[i] = {rem[i-1], num[i-1][NB-1]};
      take[i]  = (trial[i] >= {1'b0, dvs[i-1]});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= '0;
      num[0] <= n[NB-1] ? NB'(-n) : NB'(n);
      dvs[0] <= d[NB-1] ? NB'(-d) : NB'(d);
      for (int i = 1; i <= NB; i++) begin
        rem[i] <= take[i] ? NB'(trial[i] - {1'b0, dvs[i-1]}) : trial[i][NB-1:0];
        num[i] <= {num[i-1][NB-2:0], take[i]};
        dvs[i] <= dvs[i-1];
      end
    end
  end

  assign q = num[NB];
  assign r = rem[NB];

endmodule

// ===== rtl/sda_back.sv =====
module sda_back #(
  parameter int VALUE_WIDTH = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  sda_pkg::cmd_t                 head,
  input  logic                          head_valid,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [sda_pkg::VW-1:0] result_value,
  output logic [sda_pkg::SW-1:0]        result_scale,
  output logic                          equal,
  output logic                          less,
  output logic signed [sda_pkg::VW-1:0] whole_part,
  output logic signed [sda_pkg::VW-1:0] frac_part,
  output logic [1:0]                    status
);

  localparam int VW = sda_pkg::VW;
  localparam int LAT = sda_pkg::DIV_LAT;
  localparam int WRAP_SH = VW - VALUE_WIDTH;
  localparam logic signed [2*VW-1:0] WMAX = (128'sd1 <<< (VALUE_WIDTH - 1)) - 128'sd1;
  localparam logic signed [2*VW-1:0] WMIN = -WMAX - 128'sd1;
  localparam logic [VW-1:0] WMAX_U = (64'd1 << (VALUE_WIDTH - 1)) - 64'd1;

  sda_pkg::early_t e [1:4];
  sda_pkg::early_t e_in;
  sda_pkg::mid_t   m5;
  sda_pkg::mid_t   m_next;
  sda_pkg::late_t  l [6:LAT];
  sda_pkg::late_t  l_next;

  logic signed [2*VW-1:0] pa;
  logic signed [2*VW-1:0] pb;
  logic signed [VW-1:0]   div_d;
  logic [VW-1:0]          dq;
  logic [VW-1:0]          dr;
  logic signed [VW+1:0]   a66;
  logic signed [VW+1:0]   t66;
  logic signed [VW+1:0]   s66;
  logic                   adv;

  logic                   o_valid;
  logic signed [VW-1:0]   o_rv;
  logic [sda_pkg::SW-1:0] o_rs;
  logic                   o_eq;
  logic                   o_lt;
  logic signed [VW-1:0]   o_ip;
  logic signed [VW-1:0]   o_fp;
  sda_pkg::status_t       o_st;

  logic signed [VW-1:0]   f_rv;
  logic signed [VW-1:0]   f_ip;
  logic signed [VW-1:0]   f_fp;
  sda_pkg::status_t       f_st;

  function automatic logic fits(input logic signed [2*VW-1:0] v);
    return (v >= WMIN) && (v <= WMAX);
  endfunction

  function automatic logic signed [VW-1:0] wrap(input logic [VW-1:0] v);
    logic signed [VW-1:0] t;
    t = signed'(v);
    return (t <<< WRAP_SH) >>> WRAP_SH;
  endfunction

  // The whole pipeline moves together unless a finished result is held.
  assign adv = !o_valid || !out_stall;
  assign pop = adv && head_valid;

  // Entry into the pipeline.
  always_comb begin
    e_in.valid  = head_valid;
    e_in.known  = head.known;
    e_in.op     = head.op;
    e_in.a      = head.a;
    e_in.b_pos  = !head.b[VW-1] && (head.b != '0);
    e_in.k_zero = (head.k == '0);
    e_in.k_neg  = head.k[VW-1];
    e_in.sa     = head.sa;
    e_in.smax   = head.smax;
    e_in.pw     = head.pw;
    div_d       = (head.op == sda_pkg::FN_DIV) ? head.k : signed'(head.pw);
  end

  sda_mul u_mul_a (.clk(clk), .en(adv), .x(head.a), .y(head.m1), .p(pa));
  sda_mul u_mul_b (.clk(clk), .en(adv), .x(head.b), .y(head.m2), .p(pb));
  sda_div u_div (.clk(clk), .en(adv), .n(head.a), .d(div_d), .q(dq), .r(dr));

  // Products are ready: wrap and flag them, and do negate and unit steps.
  always_comb begin
    a66 = {{2{e[4].a[VW-1]}}, e[4].a};
    case (e[4].op)
      sda_pkg::FN_NEG: t66 = -a66;
      sda_pkg::FN_INC: t66 = a66 + signed'({2'b00, e[4].pw});
      default:         t66 = a66 - signed'({2'b00, e[4].pw});
    endcase
    m_next.valid  = e[4].valid;
    m_next.known  = e[4].known;
    m_next.op     = e[4].op;
    m_next.a_neg  = e[4].a[VW-1];
    m_next.b_pos  = e[4].b_pos;
    m_next.k_zero = e[4].k_zero;
    m_next.k_neg  = e[4].k_neg;
    m_next.sa     = e[4].sa;
    m_next.smax   = e[4].smax;
    m_next.x      = wrap(pa[VW-1:0]);
    m_next.y      = wrap(pb[VW-1:0]);
    m_next.ov1    = !fits(pa);
    m_next.ov2    = !fits(pb);
    m_next.rv     = '0;
    m_next.st     = sda_pkg::ST_OK;
    case (e[4].op)
      sda_pkg::FN_NEG, sda_pkg::FN_INC, sda_pkg::FN_DEC: begin
        m_next.rv = wrap(t66[VW-1:0]);
        m_next.st = fits({{(VW-2){t66[VW+1]}}, t66}) ? sda_pkg::ST_OK : sda_pkg::ST_OVF;
      end
      sda_pkg::FN_MUL: begin
        m_next.rv = wrap(pa[VW-1:0]);
        m_next.st = fits(pa) ? sda_pkg::ST_OK : sda_pkg::ST_OVF;
      end
      sda_pkg::FN_SPLIT: begin
        m_next.rv = e[4].a;
      end
      default: begin
        m_next.rv = '0;
      end
    endcase
  end

  // Aligned add, subtract and compare.
  always_comb begin
    if (m5.op == sda_pkg::FN_SUB) begin
      s66 = {{2{m5.x[VW-1]}}, m5.x} - {{2{m5.y[VW-1]}}, m5.y};
    end else begin
      s66 = {{2{m5.x[VW-1]}}, m5.x} + {{2{m5.y[VW-1]}}, m5.y};
    end
    l_next.valid  = m5.valid;
    l_next.known  = m5.known;
    l_next.op     = m5.op;
    l_next.a_neg  = m5.a_neg;
    l_next.k_zero = m5.k_zero;
    l_next.k_neg  = m5.k_neg;
    l_next.rs     = m5.sa;
    l_next.rv     = m5.rv;
    l_next.eq     = 1'b0;
    l_next.lt     = 1'b0;
    l_next.st     = m5.st;
    case (m5.op)
      sda_pkg::FN_ADD, sda_pkg::FN_SUB: begin
        l_next.rs = m5.smax;
        l_next.rv = wrap(s66[VW-1:0]);
        l_next.st = (m5.ov1 || m5.ov2 || !fits({{(VW-2){s66[VW+1]}}, s66}))
                    ? sda_pkg::ST_OVF : sda_pkg::ST_OK;
      end
      sda_pkg::FN_CMP: begin
        l_next.rs = '0;
        l_next.rv = '0;
        l_next.st = sda_pkg::ST_OK;
        if (m5.ov1) begin
          l_next.lt = m5.a_neg;
        end else if (m5.ov2) begin
          l_next.lt = m5.b_pos;
        end else begin
          l_next.eq = (m5.x == m5.y);
          l_next.lt = (signed'(m5.x) < signed'(m5.y));
        end
      end
      default: begin
        l_next.rs = m5.sa;
      end
    endcase
    if (!m5.known) begin
      l_next.rs = '0;
      l_next.rv = '0;
      l_next.eq = 1'b0;
      l_next.lt = 1'b0;
      l_next.st = sda_pkg::ST_OK;
    end
  end

  // Quotient and remainder are ready: finish divide and split.
  always_comb begin
    f_rv = l[LAT].rv;
    f_st = l[LAT].st;
    f_ip = '0;
    f_fp = '0;
    if (l[LAT].known) begin
      case (l[LAT].op)
        sda_pkg::FN_DIV: begin
          if (l[LAT].k_zero) begin
            f_rv = '0;
            f_st = sda_pkg::ST_DZ;
          end else if (l[LAT].a_neg ^ l[LAT].k_neg) begin
            f_rv = wrap(-dq);
            f_st = sda_pkg::ST_OK;
          end else begin
            f_rv = wrap(dq);
            f_st = (dq > WMAX_U) ? sda_pkg::ST_OVF : sda_pkg::ST_OK;
          end
        end
        sda_pkg::FN_SPLIT: begin
          f_ip = l[LAT].a_neg ? signed'(-dq) : signed'(dq);
          f_fp = l[LAT].a_neg ? signed'(-dr) : signed'(dr);
        end
        default: begin
          f_ip = '0;
        end
      endcase
    end
  end

  // Stage valid bits and context.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 1; i <= 4; i++) begin
        e[i].valid <= 1'b0;
      end
      m5.valid <= 1'b0;
      for (int i = 6; i <= LAT; i++) begin
        l[i].valid <= 1'b0;
      end
      o_valid <= 1'b0;
    end else if (adv) begin
      e[1] <= e_in;
      for (int i = 2; i <= 4; i++) begin
        e[i] <= e[i-1];
      end
      m5   <= m_next;
      l[6] <= l_next;
      for (int i = 7; i <= LAT; i++) begin
        l[i] <= l[i-1];
      end
      o_valid <= l[LAT].valid;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (adv) begin
      o_rv <= f_rv;
      o_rs <= l[LAT].rs;
      o_eq <= l[LAT].eq;
      o_lt <= l[LAT].lt;
      o_ip <= f_ip;
      o_fp <= f_fp;
      o_st <= f_st;
    end
  end

  assign out_valid    = o_valid;
  assign result_value = o_rv;
  assign result_scale = o_rs;
  assign equal        = o_eq;
  assign less         = o_lt;
  assign whole_part   = o_ip;
  assign frac_part    = o_fp;
  assign status       = o_st;

endmodule

// ===== rtl/scaled_decimal_alu.sv =====
// Channel  Direction  Handshake            Payload
// in       receive    in_valid / in_stall   func, a_value, a_scale, b_value, b_scale, int_operand
// out      send       out_valid / out_stall result_value, result_scale, equal, less, whole_part,
//                                           frac_part, status
//
// One transaction is accepted per cycle while the queue is not full. The depth of the back
// pipeline is set by the divider pipeline, which resolves one quotient bit per
// stage over 64 stages after a stage that takes magnitudes.
// Reset is synchronous and clears the queue and all stage valid bits; no clearing pass.
// A held result stalls the whole back pipeline; the two-entry queue keeps the input open,
// and in_stall rises only when the queue is full.
module scaled_decimal_alu #(
  parameter int MAX_SCALE   = 18,
  parameter int VALUE_WIDTH = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [sda_pkg::FW-1:0]        func,
  input  logic signed [sda_pkg::VW-1:0] a_value,
  input  logic [sda_pkg::SW-1:0]        a_scale,
  input  logic signed [sda_pkg::VW-1:0] b_value,
  input  logic [sda_pkg::SW-1:0]        b_scale,
  input  logic signed [sda_pkg::VW-1:0] int_operand,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [sda_pkg::VW-1:0] result_value,
  output logic [sda_pkg::SW-1:0]        result_scale,
  output logic                          equal,
  output logic                          less,
  output logic signed [sda_pkg::VW-1:0] whole_part,
  output logic signed [sda_pkg::VW-1:0] frac_part,
  output logic [1:0]                    status
);

  sda_pkg::cmd_t head;
  logic          head_valid;
  logic          pop;

  // Front end: classify and queue.
  sda_front #(
    .MAX_SCALE(MAX_SCALE),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .func(func),
    .a_value(a_value),
    .a_scale(a_scale),
    .b_value(b_value),
    .b_scale(b_scale),
    .int_operand(int_operand),
    .head(head),
    .head_valid(head_valid),
    .pop(pop)
  );

  // Back end: multiply, divide and format.
  sda_back #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .head(head),
    .head_valid(head_valid),
    .pop(pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .result_value(result_value),
    .result_scale(result_scale),
    .equal(equal),
    .less(less),
    .whole_part(whole_part),
    .frac_part(frac_part),
    .status(status)
  );

`ifndef SYNTHESIS
  a_cmp_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid && equal |-> !less)
    else $error("equal and less both set");

  a_dz_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == 2'(sda_pkg::ST_DZ) |-> result_value == '0 && !equal && !less)
    else $error("divide by zero result not cleared");

  a_cmp_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && (equal || less) |-> whole_part == '0 && frac_part == '0
      && status == 2'(sda_pkg::ST_OK) && result_value == '0)
    else $error("compare result carries other fields");
`endif

endmodule

// ===== sim/scaled_decimal_alu_tb.sv =====
module scaled_decimal_alu_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_SC = 18;
  localparam int LIMIT_CYCLES = 900000;
  localparam int RANDOM_ITEMS = 1630;

  typedef logic signed [sda_pkg::VW-1:0] val_t;

  // Operand set of one input transaction.
  typedef struct {
    logic [sda_pkg::FW-1:0] fn;
    val_t                   a;
    logic [sda_pkg::SW-1:0] sa;
    val_t                   b;
    logic [sda_pkg::SW-1:0] sb;
    val_t                   k;
  } op_item_t;

  // Fields of one result transaction.
  typedef struct {
    val_t                   rv;
    logic [sda_pkg::SW-1:0] rs;
    logic                   eq;
    logic                   lt;
    val_t                   ip;
    val_t                   fp;
    logic [1:0]             st;
  } decimal_result_t;

  // Directed row: stimulus plus an optional hand-written expectation.
  typedef struct {
    op_item_t        item;
    bit              has_fixed;
    decimal_result_t fixed;
  } directed_row_t;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic [sda_pkg::FW-1:0] func;
  val_t a_value;
  logic [sda_pkg::SW-1:0] a_scale;
  val_t b_value;
  logic [sda_pkg::SW-1:0] b_scale;
  val_t int_operand;
  logic out_valid;
  logic out_stall;
  val_t result_value;
  logic [sda_pkg::SW-1:0] result_scale;
  logic equal;
  logic less;
  val_t whole_part;
  val_t frac_part;
  logic [1:0] status;

  decimal_result_t pending_results[$];
  directed_row_t directed_rows[$];
  int error_count = 0;
  int cycle_count = 0;
  int send_idle_pct;
  int recv_stall_pct;

  scaled_decimal_alu u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .func(func),
    .a_value(a_value),
    .a_scale(a_scale),
    .b_value(b_value),
    .b_scale(b_scale),
    .int_operand(int_operand),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .result_value(result_value),
    .result_scale(result_scale),
    .equal(equal),
    .less(less),
    .whole_part(whole_part),
    .frac_part(frac_part),
    .status(status)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Exact power of ten built by repeated multiplication.
  function automatic logic [sda_pkg::VW-1:0] ten_to(input int n);
    logic [sda_pkg::VW-1:0] r;
    r = 1;
    for (int i = 0; i < n; i++) r = r * 10;
    return r;
  endfunction

  // Signed product with overflow, computed at double width.
  function automatic val_t mul_wrap(input val_t x, input val_t y, output bit ov);
    logic signed [2*sda_pkg::VW-1:0] p;
    p = 128'(x) * 128'(y);
    ov = (p != 128'(val_t'(p[sda_pkg::VW-1:0])));
    return p[sda_pkg::VW-1:0];
  endfunction

  // Predicts the result of one decimal operation.
  function automatic decimal_result_t decimal_predict(input op_item_t t);
    decimal_result_t r;
    int sa, sb, smax;
    val_t x, y;
    bit ov1, ov2, ov;
    logic signed [sda_pkg::VW:0] wide;
    logic [sda_pkg::VW-1:0] qa, qk, q;
    r = '{default: '0};
    sa = (t.sa > MAX_SC) ? MAX_SC : t.sa;
    sb = (t.sb > MAX_SC) ? MAX_SC : t.sb;
    smax = (sa > sb) ? sa : sb;
    case (t.fn)
      sda_pkg::FN_ADD, sda_pkg::FN_SUB: begin
        x = mul_wrap(t.a, val_t'(ten_to(smax - sa)), ov1);
        y = mul_wrap(t.b, val_t'(ten_to(smax - sb)), ov2);
        wide = (t.fn == sda_pkg::FN_ADD) ? (65'(x) + 65'(y)) : (65'(x) - 65'(y));
        ov = (wide != 65'(val_t'(wide[sda_pkg::VW-1:0])));
        r.rv = wide[sda_pkg::VW-1:0];
        r.rs = sda_pkg::SW'(smax);
        r.st = (ov1 || ov2 || ov) ? sda_pkg::ST_OVF : sda_pkg::ST_OK;
      end
      sda_pkg::FN_CMP: begin
        x = mul_wrap(t.a, val_t'(ten_to(smax - sa)), ov1);
        y = mul_wrap(t.b, val_t'(ten_to(smax - sb)), ov2);
        if (ov1) r.lt = (t.a < 0);
        else if (ov2) r.lt = (t.b > 0);
        else begin
          r.eq = (x == y);
          r.lt = (x < y);
        end
      end
      sda_pkg::FN_MUL: begin
        r.rv = mul_wrap(t.a, t.k, ov);
        r.rs = sda_pkg::SW'(sa);
        r.st = ov ? sda_pkg::ST_OVF : sda_pkg::ST_OK;
      end
      sda_pkg::FN_DIV: begin
        r.rs = sda_pkg::SW'(sa);
        if (t.k == 0) r.st = sda_pkg::ST_DZ;
        else begin
          qa = (t.a < 0) ? -t.a : t.a;
          qk = (t.k < 0) ? -t.k : t.k;
          q = qa / qk;
          if ((t.a < 0) != (t.k < 0)) r.rv = -q;
          else begin
            r.rv = q;
            r.st = q[sda_pkg::VW-1] ? sda_pkg::ST_OVF : sda_pkg::ST_OK;
          end
        end
      end
      sda_pkg::FN_NEG: begin
        wide = -65'(t.a);
        r.rv = wide[sda_pkg::VW-1:0];
        r.rs = sda_pkg::SW'(sa);
        r.st = (wide != 65'(val_t'(wide[sda_pkg::VW-1:0]))) ? sda_pkg::ST_OVF : sda_pkg::ST_OK;
      end
      sda_pkg::FN_INC, sda_pkg::FN_DEC: begin
        wide = (t.fn == sda_pkg::FN_INC) ? 65'(t.a) + 65'(ten_to(sa))
                                         : 65'(t.a) - 65'(ten_to(sa));
        r.rv = wide[sda_pkg::VW-1:0];
        r.rs = sda_pkg::SW'(sa);
        r.st = (wide != 65'(val_t'(wide[sda_pkg::VW-1:0]))) ? sda_pkg::ST_OVF : sda_pkg::ST_OK;
      end
      sda_pkg::FN_SPLIT: begin
        r.rv = t.a;
        r.rs = sda_pkg::SW'(sa);
        r.ip = t.a / val_t'(ten_to(sa));
        r.fp = t.a % val_t'(ten_to(sa));
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic val_t rand_value();
    val_t v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: v = $signed(v) >>> $urandom_range(0, 63);
      1: v = val_t'($urandom_range(0, 40)) - 20;
      2: v = ($urandom_range(0, 1) ? 64'h7fff_ffff_ffff_ffff : 64'h8000_0000_0000_0000)
             + val_t'($urandom_range(0, 4)) - 2;
      3: v = $signed(v) >>> $urandom_range(20, 62);
      default: ;
    endcase
    return v;
  endfunction

  function automatic op_item_t rand_item();
    op_item_t t;
    t.fn = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));
    t.a = rand_value();
    t.b = rand_value();
    t.k = ($urandom_range(0, 15) == 0) ? val_t'(0) : rand_value();
    t.sa = ($urandom_range(0, 9) == 0) ? 5'($urandom) : 5'($urandom_range(0, MAX_SC));
    t.sb = ($urandom_range(0, 9) == 0) ? 5'($urandom) : 5'($urandom_range(0, MAX_SC));
    return t;
  endfunction

  function automatic directed_row_t row(input logic [sda_pkg::FW-1:0] fn, input val_t a,
                                        input logic [sda_pkg::SW-1:0] sa, input val_t b,
                                        input logic [sda_pkg::SW-1:0] sb, input val_t k);
    directed_row_t d;
    d.item = '{fn, a, sa, b, sb, k};
    d.has_fixed = 1'b0;
    d.fixed = '{default: '0};
    return d;
  endfunction

  function automatic directed_row_t row_fixed(input directed_row_t d, input val_t rv,
                                              input logic [sda_pkg::SW-1:0] rs,
                                              input logic [1:0] st);
    d.has_fixed = 1'b1;
    d.fixed.rv = rv;
    d.fixed.rs = rs;
    d.fixed.st = st;
    return d;
  endfunction

  // Drives one transaction and holds it until it is accepted.
  task automatic send_item(input op_item_t t, input decimal_result_t expected);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    func <= t.fn;
    a_value <= t.a;
    a_scale <= t.sa;
    b_value <= t.b;
    b_scale <= t.sb;
    int_operand <= t.k;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(expected);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // Receiver stall pattern.
  always @(negedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Result checking against the oldest expectation.
  always @(posedge clk) begin
    decimal_result_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result transaction with nothing expected");
        error_count++;
      end else begin
        e = pending_results.pop_front();
        if (result_value !== e.rv) begin
          $error("result_value expected %0d got %0d", e.rv, result_value);
          error_count++;
        end
        if (result_scale !== e.rs) begin
          $error("result_scale expected %0d got %0d", e.rs, result_scale);
          error_count++;
        end
        if (equal !== e.eq) begin
          $error("equal expected %0d got %0d", e.eq, equal);
          error_count++;
        end
        if (less !== e.lt) begin
          $error("less expected %0d got %0d", e.lt, less);
          error_count++;
        end
        if (whole_part !== e.ip) begin
          $error("whole_part expected %0d got %0d", e.ip, whole_part);
          error_count++;
        end
        if (frac_part !== e.fp) begin
          $error("frac_part expected %0d got %0d", e.fp, frac_part);
          error_count++;
        end
        if (status !== e.st) begin
          $error("status expected %0d got %0d", e.st, status);
          error_count++;
        end
      end
    end
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("scaled_decimal_alu_tb: done, errors");
      $finish;
    end
  end

  // Stimulus sequence.
  initial begin
    val_t vmax, vmin;
    decimal_result_t e;
    op_item_t t;
    vmax = 64'h7fff_ffff_ffff_ffff;
    vmin = 64'h8000_0000_0000_0000;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    func = '0;
    a_value = '0;
    a_scale = '0;
    b_value = '0;
    b_scale = '0;
    int_operand = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed rows: extremes, every operation and the special cases.
    directed_rows.push_back(row_fixed(row(sda_pkg::FN_ADD, 15, 1, 25, 2, 0), 175, 2,
                                      sda_pkg::ST_OK));
    directed_rows.push_back(row_fixed(row(sda_pkg::FN_ADD, vmax, 0, 1, 0, 0), vmin, 0,
                                      sda_pkg::ST_OVF));
    directed_rows.push_back(row_fixed(row(sda_pkg::FN_SUB, vmin, 0, 1, 0, 0), vmax, 0,
                                      sda_pkg::ST_OVF));
    directed_rows.push_back(row(sda_pkg::FN_SUB, vmax, 0, 3, 18, 0));
    directed_rows.push_back(row(sda_pkg::FN_CMP, 10, 1, 1, 0, 0));
    directed_rows.push_back(row(sda_pkg::FN_CMP, vmin, 0, 5, 18, 0));
    directed_rows.push_back(row(sda_pkg::FN_CMP, -5, 18, vmax, 0, 0));
    directed_rows.push_back(row(sda_pkg::FN_CMP, vmax, 31, vmin, 31, 0));
    directed_rows.push_back(row_fixed(row(sda_pkg::FN_MUL, vmin, 3, 0, 0, -1), vmin, 3,
                                      sda_pkg::ST_OVF));
    directed_rows.push_back(row(sda_pkg::FN_MUL, -123456, 4, 0, 0, 987654321));
    directed_rows.push_back(row_fixed(row(sda_pkg::FN_DIV, 77, 5, 0, 0, 0), 0, 5,
                                      sda_pkg::ST_DZ));
    directed_rows.push_back(row_fixed(row(sda_pkg::FN_DIV, vmin, 2, 0, 0, -1), vmin, 2,
                                      sda_pkg::ST_OVF));
    directed_rows.push_back(row(sda_pkg::FN_DIV, -7, 0, 0, 0, 2));
    directed_rows.push_back(row(sda_pkg::FN_DIV, vmax, 18, 0, 0, vmin));
    directed_rows.push_back(row_fixed(row(sda_pkg::FN_NEG, vmin, 0, 0, 0, 0), vmin, 0,
                                      sda_pkg::ST_OVF));
    directed_rows.push_back(row(sda_pkg::FN_NEG, vmax, 7, 0, 0, 0));
    directed_rows.push_back(row(sda_pkg::FN_INC, vmax - 5, 0, 0, 0, 0));
    directed_rows.push_back(row(sda_pkg::FN_INC, -1, 18, 0, 0, 0));
    directed_rows.push_back(row(sda_pkg::FN_DEC, vmin, 25, 0, 0, 0));
    directed_rows.push_back(row(sda_pkg::FN_SPLIT, -12345, 2, 0, 0, 0));
    directed_rows.push_back(row(sda_pkg::FN_SPLIT, vmin, 18, 0, 0, 0));
    directed_rows.push_back(row(sda_pkg::FN_SPLIT, vmax, 0, 0, 0, 0));
    directed_rows.push_back(row_fixed(row(4'd15, -1, 31, -1, 31, -1), 0, 0, sda_pkg::ST_OK));
    foreach (directed_rows[i]) begin
      e = directed_rows[i].has_fixed ? directed_rows[i].fixed
                                     : decimal_predict(directed_rows[i].item);
      send_item(directed_rows[i].item, e);
    end
    // Hold off the sender until every expected result has arrived.
    drain_results();

    // Random part over the idling phases.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      case (n * 5 / RANDOM_ITEMS)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
        3: begin send_idle_pct = 33; recv_stall_pct = 33; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      t = rand_item();
      send_item(t, decimal_predict(t));
    end
    drain_results();
    repeat (sda_pkg::DIV_LAT + 10) @(posedge clk);
    if (error_count == 0) $display("scaled_decimal_alu_tb: done, clean");
    else $display("scaled_decimal_alu_tb: done, errors");
    $finish;
  end

endmodule
